// ===== rtl/assert_macros.svh =====
// Assertion macros for the port-level checker bsc_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while reset is released.
`define BSC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define BSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bsc_pkg.sv =====
// Shared types and constants of the barometric compensation block.
package bsc_pkg;

  localparam int unsigned INQ_DEPTH = 4;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DVD_W     = 32;
  localparam int unsigned DVS_W     = 21;

  localparam logic signed [28:0] T_OFFSET  = 29'sd4000;
  localparam logic [31:0]        P_SCALE   = 32'd50000;
  localparam logic [11:0]        P_C1      = 12'd3038;
  localparam logic signed [14:0] P_C2      = -15'sd7357;
  localparam logic signed [46:0] P_C3      = 47'sd3791;
  localparam logic [31:0]        X3_BIAS   = 32'd32768;
  localparam logic [17:0]        PRESS_MAX = 18'd262143;

  typedef enum logic [2:0] {
    CFG_AC1_AC2 = 3'd0,
    CFG_AC3_AC4 = 3'd1,
    CFG_AC5_AC6 = 3'd2,
    CFG_B1_B2   = 3'd3,
    CFG_MC_MD   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] ac1_ac2;
    logic [31:0] ac3_ac4;
    logic [31:0] ac5_ac6;
    logic [31:0] b1_b2;
    logic [31:0] mc_md;
  } cfg_t;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [15:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [17:0]        pressure_pascal;
    logic               divide_error;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_X1, S_DEN, S_TDIV, S_B6, S_SQ, S_MA, S_MB, S_MC, S_MD,
    S_B3, S_B4, S_B7, S_PDIV, S_P1, S_P2, S_P3, S_FIN, S_OUT
  } back_st_e;

endpackage

// ===== rtl/bsc_inq.sv =====
// Front input queue: holds raw reading pairs until the back end takes them.
module bsc_inq (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         full_o,
  input  bsc_pkg::in_t wdata_i,
  input  logic         pop_i,
  output logic         empty_o,
  output bsc_pkg::in_t rdata_o
);
  import bsc_pkg::*;

  localparam int unsigned PW = $clog2(INQ_DEPTH);

  in_t           mem_q [INQ_DEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(INQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(INQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(INQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/bsc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
module bsc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsc_pkg::div_req_t req_i,
  output bsc_pkg::div_rsp_t rsp_o
);
  import bsc_pkg::*;

  localparam int unsigned CW = $clog2(DIV_STEPS);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W:0]   shifted, diff;
  logic             qbit;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign qbit    = !diff[DVS_W];

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      quo_q <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], qbit};
    end
  end

endmodule

// ===== rtl/bsc_back.sv =====
// Back end: sequences the compensation arithmetic and holds the result beat.
module bsc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bsc_pkg::cfg_t cfg_i,
  input  logic          q_empty_i,
  input  bsc_pkg::in_t  q_data_i,
  output logic          q_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output bsc_pkg::out_t res_o
);
  import bsc_pkg::*;

  back_st_e st_q, st_d;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;

  assign ac1 = $signed(cfg_i.ac1_ac2[31:16]);
  assign ac2 = $signed(cfg_i.ac1_ac2[15:0]);
  assign ac3 = $signed(cfg_i.ac3_ac4[31:16]);
  assign ac4 = cfg_i.ac3_ac4[15:0];
  assign ac5 = cfg_i.ac5_ac6[31:16];
  assign ac6 = cfg_i.ac5_ac6[15:0];
  assign b1  = $signed(cfg_i.b1_b2[31:16]);
  assign b2  = $signed(cfg_i.b1_b2[15:0]);
  assign mc  = $signed(cfg_i.mc_md[31:16]);
  assign md  = $signed(cfg_i.mc_md[15:0]);

  // datapath registers
  logic [15:0]        ut_q, up_q;
  logic signed [19:0] x1_q;
  logic               neg_q, err_q, hi_q, res_valid_q;
  logic signed [28:0] b5_q, b6_q;
  logic signed [15:0] t_q;
  logic signed [45:0] sq12_q;
  logic signed [33:0] ma_q;
  logic signed [31:0] mb_q;
  logic signed [50:0] mc_q;
  logic signed [45:0] mdp_q;
  logic [31:0]        b3lo_q, v_q, p_q;
  logic [16:0]        b4_q;
  logic [47:0]        psq_q;
  logic [43:0]        px1_q;
  logic signed [30:0] px2_q;
  logic [17:0]        pres_q;
  out_t               res_q;

  // combinational arithmetic
  logic signed [17:0] ut_diff;
  logic signed [34:0] x1_prod;
  logic signed [20:0] den;
  logic signed [26:0] num;
  logic [26:0]        num_mag;
  logic [20:0]        den_mag;
  logic signed [27:0] q28, x2;
  logic signed [29:0] b5p8, t30;
  logic signed [57:0] sq;
  logic signed [44:0] pa, pb;
  logic signed [61:0] pc, pd;
  logic signed [52:0] n3, b3;
  logic signed [47:0] xs, x3;
  logic [31:0]        b4p, b7, pu;
  logic [23:0]        ps;
  logic [59:0]        pe;
  logic signed [46:0] pm, ssum, corr, pfin;
  logic               res_load;

  bsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    ut_diff = $signed({2'b00, ut_q}) - $signed({2'b00, ac6});
    x1_prod = ut_diff * $signed({1'b0, ac5});
    den     = 21'(x1_q) + 21'(md);
    num     = $signed({mc, 11'b0});
    num_mag = num[26] ? 27'(-num) : num;
    den_mag = den[20] ? 21'(-den) : den;
    q28     = $signed(div_rsp.quotient[27:0]);
    x2      = neg_q ? -q28 : q28;
    b5p8    = 30'(b5_q) + 30'sd8;
    t30     = b5p8 >>> 4;
    sq      = b6_q * b6_q;
    pa      = ac2 * b6_q;
    pb      = ac3 * b6_q;
    pc      = b2 * sq12_q;
    pd      = b1 * sq12_q;
    n3      = (53'(ac1) <<< 2) + 53'(mc_q) + 53'(ma_q) + 53'sd2;
    // truncate toward zero
    b3      = n3[52] ? ((n3 + 53'sd3) >>> 2) : (n3 >>> 2);
    xs      = 48'(mb_q) + 48'(mdp_q) + 48'sd2;
    x3      = xs >>> 2;
    b4p     = 32'(ac4 * v_q);
    b7      = 32'((32'(up_q) - b3lo_q) * P_SCALE);
    pu      = hi_q ? {div_rsp.quotient[30:0], 1'b0} : div_rsp.quotient;
    ps      = p_q[31:8];
    pe      = psq_q * 60'(P_C1);
    pm      = 47'(P_C2) * $signed({15'b0, p_q});
    ssum    = $signed({3'b000, px1_q}) + 47'(px2_q) + P_C3;
    corr    = ssum >>> 4;
    pfin    = $signed({15'b0, p_q}) + corr;
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (!q_empty_i) st_d = S_X1;
      S_X1:   st_d = S_DEN;
      S_DEN:  st_d = (den == '0) ? S_OUT : S_TDIV;
      S_TDIV: if (div_rsp.done) st_d = S_B6;
      S_B6:   st_d = S_SQ;
      S_SQ:   st_d = S_MA;
      S_MA:   st_d = S_MB;
      S_MB:   st_d = S_MC;
      S_MC:   st_d = S_MD;
      S_MD:   st_d = S_B3;
      S_B3:   st_d = S_B4;
      S_B4:   st_d = S_B7;
      S_B7:   st_d = (b4_q == '0) ? S_OUT : S_PDIV;
      S_PDIV: if (div_rsp.done) st_d = S_P1;
      S_P1:   st_d = S_P2;
      S_P2:   st_d = S_P3;
      S_P3:   st_d = S_FIN;
      S_FIN:  st_d = S_OUT;
      S_OUT:  if (!res_valid_q || pop_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop_o          = 1'b0;
    res_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {5'b0, num_mag};
    div_req.divisor  = den_mag;
    case (st_q)
      S_IDLE: q_pop_o = !q_empty_i;
      S_DEN:  div_req.start = (den != '0);
      S_B7: begin
        div_req.start    = (b4_q != '0);
        div_req.dividend = b7[31] ? b7 : {b7[30:0], 1'b0};
        div_req.divisor  = {4'b0, b4_q};
      end
      S_OUT:  res_load = !res_valid_q || pop_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        ut_q  <= q_data_i.raw_temperature;
        up_q  <= q_data_i.raw_pressure;
        err_q <= 1'b0;
      end
      S_X1:   x1_q <= x1_prod[34:15];
      S_DEN: begin
        neg_q <= num[26] ^ den[20];
        err_q <= (den == '0);
      end
      S_TDIV: b5_q <= 29'(x1_q) + 29'(x2);
      S_B6: begin
        if (t30 > 30'sd32767) begin
          t_q <= 16'sh7fff;
        end else if (t30 < -30'sd32768) begin
          t_q <= 16'sh8000;
        end else begin
          t_q <= t30[15:0];
        end
        b6_q <= b5_q - T_OFFSET;
      end
      S_SQ:   sq12_q <= sq[57:12];
      S_MA:   ma_q   <= pa[44:11];
      S_MB:   mb_q   <= pb[44:13];
      S_MC:   mc_q   <= pc[61:11];
      S_MD:   mdp_q  <= pd[61:16];
      S_B3: begin
        b3lo_q <= b3[31:0];
        v_q    <= x3[31:0] + X3_BIAS;
      end
      S_B4: b4_q <= b4p[31:15];
      S_B7: begin
        hi_q  <= b7[31];
        err_q <= (b4_q == '0);
      end
      S_PDIV: p_q   <= pu;
      S_P1:   psq_q <= ps * ps;
      S_P2:   px1_q <= pe[59:16];
      S_P3:   px2_q <= pm[46:16];
      S_FIN: begin
        if (pfin < 47'sd0) begin
          pres_q <= '0;
        end else if (pfin > 47'(PRESS_MAX)) begin
          pres_q <= PRESS_MAX;
        end else begin
          pres_q <= pfin[17:0];
        end
      end
      default: ;
    endcase
    if (res_load) begin
      res_q.temperature_tenths <= err_q ? '0 : t_q;
      res_q.pressure_pascal    <= err_q ? '0 : pres_q;
      res_q.divide_error       <= err_q;
    end
  end

  assign empty_o = !res_valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/barometric_sensor_compensation.sv =====
// Top level of the barometric temperature and pressure compensation block.
// Usage:
//   Input channel: drive in_data_i and raise push; a beat is taken at an edge
//   where push is high and full is low. Up to four reading pairs queue ahead
//   of the arithmetic, so pushes may come in consecutive cycles.
//   Result channel: while empty is low, out_data_o holds the oldest result;
//   it is taken at an edge where pop is high. Results leave in input order.
//   Configuration: write the five calibration words through cfg_valid_i,
//   cfg_index_i and cfg_data_i while the block is idle; cfg_ready_o is
//   always high. Indexes beyond the list are dropped.
// Timing: the back end uses the shared 32-step radix-2 divider, which runs
//   once for the temperature term and once for the pressure term (a zero
//   divisor ends the item early); it takes a new reading only after the
//   previous result has been loaded into the output slot.
// Reset clears the queue, the result slot and all calibration words.
// When the receiver stalls, the finished result holds in the output slot,
//   the next item is still computed and waits, and the queue keeps filling
//   until full rises.
module barometric_sensor_compensation (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  bsc_pkg::in_t  in_data_i,
  output logic          empty,
  input  logic          pop,
  output bsc_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);
  import bsc_pkg::*;

  cfg_t cfg_q;
  logic q_empty, q_pop;
  in_t  q_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_AC1_AC2: cfg_q.ac1_ac2 <= cfg_data_i;
        CFG_AC3_AC4: cfg_q.ac3_ac4 <= cfg_data_i;
        CFG_AC5_AC6: cfg_q.ac5_ac6 <= cfg_data_i;
        CFG_B1_B2:   cfg_q.b1_b2   <= cfg_data_i;
        CFG_MC_MD:   cfg_q.mc_md   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bsc_inq u_inq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .wdata_i (in_data_i),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_data)
  );

  bsc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .res_o     (out_data_o)
  );

endmodule

// ===== rtl/bsc_chk.sv =====
// Port-level checker for the compensation block, bound to the top level.
`include "assert_macros.svh"

module bsc_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input bsc_pkg::out_t out_data_o
);

  `BSC_ASSERT_ALWAYS(a_reset_clear, clk_i, !rst_ni |-> (empty && !full), "reset must clear both sides")
  `BSC_ASSERT(a_err_zero, clk_i, rst_ni, (!empty && out_data_o.divide_error) |-> (out_data_o.temperature_tenths == '0 && out_data_o.pressure_pascal == '0), "error beat must carry zero results")
  `BSC_ASSERT(a_hold, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(out_data_o)), "stalled result beat must hold")

endmodule

bind barometric_sensor_compensation bsc_chk u_bsc_chk (.*);

// ===== dv/bsc_checker.sv =====
// Watches the reading, result and calibration channels, predicts each result and compares.
module bsc_checker
  import bsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  in_t         in_data_i,
  input  logic        empty,
  input  logic        pop,
  input  out_t        out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [31:0] cal_q [5];
  out_t        expected_results [$];
  int unsigned fail_count;

  function automatic out_t compensate(in_t rd);
    longint ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
    longint x1, x2, x3, b5, b6, b3, den, t, p, sq;
    logic [31:0] ac4, up, b3_lo, bias, b4, b7, pu;
    out_t res;
    res = '0;
    res.divide_error = 1'b1;
    ac1 = longint'($signed(cal_q[CFG_AC1_AC2][31:16]));
    ac2 = longint'($signed(cal_q[CFG_AC1_AC2][15:0]));
    ac3 = longint'($signed(cal_q[CFG_AC3_AC4][31:16]));
    ac4 = {16'd0, cal_q[CFG_AC3_AC4][15:0]};
    ac5 = cal_q[CFG_AC5_AC6][31:16];
    ac6 = cal_q[CFG_AC5_AC6][15:0];
    b1  = longint'($signed(cal_q[CFG_B1_B2][31:16]));
    b2  = longint'($signed(cal_q[CFG_B1_B2][15:0]));
    mc  = longint'($signed(cal_q[CFG_MC_MD][31:16]));
    md  = longint'($signed(cal_q[CFG_MC_MD][15:0]));
    ut  = rd.raw_temperature;
    up  = {16'd0, rd.raw_pressure};

    x1  = ((ut - ac6) * ac5) >>> 15;
    den = x1 + md;
    if (den == 0) return res;
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    t  = (b5 + 8) >>> 4;

    b6 = b5 - 4000;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = (ac1 * 4 + x3 + 2) / 4;   // truncates toward zero
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    bias = x3 + 32768;             // wrap to 32 bits
    b4 = (ac4 * bias) >> 15;
    if (b4 == 0) return res;
    b3_lo = b3;
    b7 = (up - b3_lo) * 32'd50000;
    if (b7 < 32'h8000_0000) pu = (b7 * 32'd2) / b4;
    else                    pu = (b7 / b4) * 32'd2;

    p  = pu;
    x1 = (p >> 8) * (p >> 8);
    x1 = (x1 * 3038) >> 16;
    x2 = (-7357 * p) >>> 16;
    p  = p + ((x1 + x2 + 3791) >>> 4);

    if (t < -32768) t = -32768;
    if (t > 32767)  t = 32767;
    if (p < 0)      p = 0;
    if (p > 262143) p = 262143;
    res.temperature_tenths = t[15:0];
    res.pressure_pascal    = p[17:0];
    res.divide_error       = 1'b0;
    return res;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      foreach (cal_q[i]) cal_q[i] = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_index_i <= CFG_MC_MD) begin
        cal_q[cfg_index_i] = cfg_data_i;
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report("unexpected result beat", 0, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.temperature_tenths !== want.temperature_tenths)
            report("temperature_tenths", out_data_i.temperature_tenths,
                   want.temperature_tenths);
          if (out_data_i.pressure_pascal !== want.pressure_pascal)
            report("pressure_pascal", out_data_i.pressure_pascal, want.pressure_pascal);
          if (out_data_i.divide_error !== want.divide_error)
            report("divide_error", out_data_i.divide_error, want.divide_error);
        end
      end
      if (push && !full) expected_results.push_back(compensate(in_data_i));
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_results.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top: drives readings, calibration writes and result pops, and gives the verdict.
module tb;
  import bsc_pkg::*;

  localparam int unsigned  CYCLE_LIMIT = 3_000_000;
  localparam logic [2:0]   CFG_UNUSED_LO = 3'd5;
  localparam logic [2:0]   CFG_UNUSED_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push = 1'b0;
  logic        full;
  in_t         in_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int unsigned fail_count, pending;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;
  bit          long_hold = 1'b0;

  always #5 clk = ~clk;

  barometric_sensor_compensation i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .push(push), .full(full), .in_data_i(in_data),
    .empty(empty), .pop(pop), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  bsc_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .push(push), .full(full), .in_data_i(in_data),
    .empty(empty), .pop(pop), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off when asked.
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        pop <= 1'b0;
        long_hold = 1'b0;
        repeat (600) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_cal(input logic [31:0] w0, w1, w2, w3, w4);
    write_reg(CFG_AC1_AC2, w0);
    write_reg(CFG_AC3_AC4, w1);
    write_reg(CFG_AC5_AC6, w2);
    write_reg(CFG_B1_B2, w3);
    write_reg(CFG_MC_MD, w4);
    write_reg(3'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), $urandom);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send(input logic [15:0] ut, input logic [15:0] up);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= '{raw_temperature: ut, raw_pressure: up};
    do @(posedge clk); while (full);
  endtask

  // Hold until every result is back, plus the block's latency.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_items(input int count);
    repeat (count) begin
      if ($urandom_range(0, 1)) send($urandom_range(20000, 35000), $urandom_range(15000, 45000));
      else                      send($urandom, $urandom);
    end
  endtask

  // Typical calibration, slightly perturbed when jitter is set.
  task automatic load_typical(input bit jitter);
    logic [15:0] d;
    d = jitter ? 16'($urandom_range(0, 63)) : 16'd0;
    load_cal({16'd408 + d, -16'sd72}, {-16'sd14383, 16'd32741 + d},
             {16'd32757 - d, 16'd23153 + d}, {16'd6190, 16'd4 + d},
             {-16'sd8711, 16'd2868 + d});
  endtask

  initial begin
    // Assert reset after every process waits, so the falling edge is seen.
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_typical(1'b0);
    send(16'd0, 16'd0);
    send(16'hFFFF, 16'hFFFF);
    send(16'd27898, 16'd23843);
    send(16'd23153, 16'd0);
    send(16'd0, 16'hFFFF);
    send(16'hFFFF, 16'd0);
    send(16'h5555, 16'hAAAA);
    send(16'hAAAA, 16'h5555);
    drain();

    // Temperature divisor zero: UT equal to AC6 and MD of zero.
    load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
             {16'd6190, 16'd4}, {-16'sd8711, 16'd0});
    send(16'd23153, 16'd30000);
    send(16'd27898, 16'd23843);
    drain();

    // Pressure divisor zero: AC4 of zero.
    load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd0}, {16'd32757, 16'd23153},
             {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
    send(16'd27898, 16'd23843);
    drain();

    load_cal('1, '1, '1, '1, '1);
    send(16'd0, 16'd0);
    send(16'hFFFF, 16'hFFFF);
    send(16'd1234, 16'd40000);
    drain();

    load_cal('0, '0, '0, '0, '0);
    send(16'd1, 16'd1);
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 0) long_hold = 1'b1;
      if (phase == 6) quiet = 1'b1;
      if (phase % 2 == 0) load_typical(1'b1);
      else                load_cal($urandom, $urandom, $urandom, $urandom, $urandom);
      random_items(265);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
